FILE: hdl/bac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat package
// Shared types, codes and constants for the button auto-repeat controller.
// ----------------------------------------------------------------------------
package bac_pkg;

  localparam int NUM_BUTTONS = 10;
  localparam int BUTTON_W    = 4;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int DPAD_W      = 2;

  localparam logic [BUTTON_W-1:0] BTN_A      = 4'd4;
  localparam logic [BUTTON_W-1:0] BTN_B      = 4'd5;
  localparam logic [BUTTON_W-1:0] BTN_L      = 4'd6;
  localparam logic [BUTTON_W-1:0] BTN_R      = 4'd7;
  localparam logic [BUTTON_W-1:0] BTN_SELECT = 4'd8;
  localparam logic [BUTTON_W-1:0] BTN_LIMIT  = 4'd10;
  localparam logic [BUTTON_W-1:0] DPAD_LIMIT = 4'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DELAY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;

  localparam logic [CFG_W-1:0] INITIAL_DELAY_RESET   = 16'd400;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_PRESS      = 2'd0,
    OP_RELEASE    = 2'd1,
    OP_TICK       = 2'd2,
    OP_FOCUS_LOST = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [BUTTON_W-1:0]   button;
    logic [TIME_W-1:0]     time_ms;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] initial_delay_ms;
    logic [CFG_W-1:0] repeat_interval_ms;
  } cfg_t;

endpackage

FILE: hdl/bac_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat channel interfaces
// Command, event and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bac_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  button;
  logic [31:0] time_ms;

  modport source (output valid, output opcode, output button, output time_ms,
                  input ready);
  modport sink (input valid, input opcode, input button, input time_ms,
                output ready);
endinterface

interface bac_evt_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_button;
  logic       released;
  logic       mod_a;
  logic       mod_b;
  logic       mod_l;
  logic       mod_r;
  logic       mod_select;

  modport source (output valid, output event_button, output released,
                  output mod_a, output mod_b, output mod_l, output mod_r,
                  output mod_select, input ready);
  modport sink (input valid, input event_button, input released,
                input mod_a, input mod_b, input mod_l, input mod_r,
                input mod_select, output ready);
endinterface

interface bac_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

FILE: hdl/button_autorepeat_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat controller
// Press, release, repeat and focus handling for ten logical buttons.
// ----------------------------------------------------------------------------
// The block takes one request per clock on cmd while evt is not stalled and
// returns at most one event per request on evt. A request passes the input
// register and then the event register, with the mask, repeat and deadline
// update in between; a request with no event still passes the input register.
// cmd.ready follows evt.ready combinationally through the input register, so
// a stalled event holds the queued request, and a full input register holds cmd.
// Registers on cfg (index 0 initial delay, index 1 repeat interval, in ms) are
// always ready and should be written only while no request is in flight.
module button_autorepeat_controller
  import bac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bac_cmd_if.sink   cmd,
  bac_evt_if.source evt,
  bac_cfg_if.sink   cfg
);

  cfg_t  regs;
  item_t item;
  logic  item_valid;
  logic  take;

  bac_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bac_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  bac_core u_core (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .evt        (evt)
  );

endmodule

FILE: hdl/bac_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat configuration registers
// Holds the initial delay and the repeat interval written over the cfg port.
// ----------------------------------------------------------------------------
module bac_cfg_regs
  import bac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bac_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.initial_delay_ms   <= INITIAL_DELAY_RESET;
      regs.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_INITIAL_DELAY:   regs.initial_delay_ms   <= cfg.data;
        CFG_REPEAT_INTERVAL: regs.repeat_interval_ms <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/bac_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat input stage
// Registers one request from the command channel until the core takes it.
// ----------------------------------------------------------------------------
module bac_in_stage
  import bac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bac_cmd_if.sink   cmd,
  input  logic      take,
  output logic      item_valid,
  output item_t     item
);

  logic load;

  // The slot refills in the same cycle the core drains it.
  assign cmd.ready = !item_valid || take;
  assign load      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.opcode  <= opcode_t'(cmd.opcode);
      item.button  <= cmd.button;
      item.time_ms <= cmd.time_ms;
    end
  end

endmodule

FILE: hdl/bac_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat core
// Held mask, repeat state and deadline, plus the registered event output.
// ----------------------------------------------------------------------------
module bac_core
  import bac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      regs,
  input  logic      item_valid,
  input  item_t     item,
  output logic      take,
  bac_evt_if.source evt
);

  logic [NUM_BUTTONS-1:0] held_mask;
  logic [NUM_BUTTONS-1:0] held_mask_next;
  logic                   repeat_on;
  logic                   repeat_on_next;
  logic [DPAD_W-1:0]      repeat_target;
  logic [DPAD_W-1:0]      repeat_target_next;
  logic [TIME_W-1:0]      next_deadline;
  logic [TIME_W-1:0]      next_deadline_next;

  logic                   emit;
  logic [BUTTON_W-1:0]    emit_button;
  logic                   emit_released;
  logic                   button_ok;
  logic [NUM_BUTTONS-1:0] bit_sel;
  logic                   is_held;
  logic [TIME_W-1:0]      since_deadline;
  logic                   out_free;

  assign out_free = !evt.valid || evt.ready;
  assign take     = item_valid && out_free;

  assign button_ok      = item.button < BTN_LIMIT;
  assign bit_sel        = button_ok ? (NUM_BUTTONS'(1) << item.button) : '0;
  assign is_held        = |(held_mask & bit_sel);
  assign since_deadline = item.time_ms - next_deadline;

  always_comb begin
    held_mask_next     = held_mask;
    repeat_on_next     = repeat_on;
    repeat_target_next = repeat_target;
    next_deadline_next = next_deadline;
    emit               = 1'b0;
    emit_button        = item.button;
    emit_released      = 1'b0;
    case (item.opcode)
      OP_PRESS: begin
        if (button_ok && !is_held) begin
          held_mask_next = held_mask | bit_sel;
          emit           = 1'b1;
          if (item.button < DPAD_LIMIT) begin
            repeat_on_next     = 1'b1;
            repeat_target_next = item.button[DPAD_W-1:0];
            next_deadline_next = item.time_ms + TIME_W'(regs.initial_delay_ms);
          end
        end
      end
      OP_RELEASE: begin
        if (is_held) begin
          held_mask_next = held_mask & ~bit_sel;
          emit           = 1'b1;
          emit_released  = 1'b1;
          if (item.button == {{(BUTTON_W-DPAD_W){1'b0}}, repeat_target} ||
              item.button == BTN_A || item.button == BTN_B) begin
            repeat_on_next = 1'b0;
          end
        end
      end
      OP_TICK: begin
        // Due when the wrapped distance past the deadline is non-negative.
        if (repeat_on && !since_deadline[TIME_W-1]) begin
          emit               = 1'b1;
          emit_button        = {{(BUTTON_W-DPAD_W){1'b0}}, repeat_target};
          next_deadline_next = item.time_ms + TIME_W'(regs.repeat_interval_ms);
        end
      end
      OP_FOCUS_LOST: begin
        held_mask_next = '0;
        repeat_on_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask     <= '0;
      repeat_on     <= 1'b0;
      repeat_target <= '0;
      next_deadline <= '0;
    end else if (take) begin
      held_mask     <= held_mask_next;
      repeat_on     <= repeat_on_next;
      repeat_target <= repeat_target_next;
      next_deadline <= next_deadline_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (out_free) begin
      evt.valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      evt.event_button <= emit_button;
      evt.released     <= emit_released;
      evt.mod_a        <= held_mask_next[BTN_A];
      evt.mod_b        <= held_mask_next[BTN_B];
      evt.mod_l        <= held_mask_next[BTN_L];
      evt.mod_r        <= held_mask_next[BTN_R];
      evt.mod_select   <= held_mask_next[BTN_SELECT];
    end
  end

endmodule

FILE: hdl/bac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat port checker
// Checks the event port of the controller over time; bound to the top level.
// ----------------------------------------------------------------------------
module bac_checker
  import bac_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                evt_valid,
  input logic                evt_ready,
  input logic [BUTTON_W-1:0] evt_button,
  input logic                evt_released,
  input logic                evt_mod_a,
  input logic                evt_mod_b
);

  // An event waiting on the sink keeps its button and released flag.
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_button) &&
    $stable(evt_released))
    else $error("event changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !evt_valid)
    else $error("event valid right after reset");

  a_button_range: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> evt_button < BTN_LIMIT)
    else $error("event button out of range");

  // The snapshot is taken after the update, so A and B reflect their own event.
  a_mod_a_snapshot: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_button == BTN_A |-> evt_mod_a == !evt_released)
    else $error("A modifier disagrees with its own event");

  a_mod_b_snapshot: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_button == BTN_B |-> evt_mod_b == !evt_released)
    else $error("B modifier disagrees with its own event");

endmodule

bind button_autorepeat_controller bac_checker u_bac_checker (
  .clk          (clk),
  .rst          (rst),
  .evt_valid    (evt.valid),
  .evt_ready    (evt.ready),
  .evt_button   (evt.event_button),
  .evt_released (evt.released),
  .evt_mod_a    (evt.mod_a),
  .evt_mod_b    (evt.mod_b)
);

FILE: verif/button_autorepeat_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button auto-repeat controller testbench
// Drives press, release, tick and focus-lost requests through the command
// channel with random gaps and event stalls, predicts every event from a
// behavioral copy of the held mask and repeat state, and checks each event
// field by field in order. Delay and interval registers are changed between
// phases, including both extremes.
// ----------------------------------------------------------------------------
module button_autorepeat_controller_test;
  import bac_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES      = 7;
  localparam int STALL_LIMIT     = 2000;
  localparam int PRINT_LIMIT     = 50;
  localparam int MAX_ITEMS       = 2048;

  // Indexes that select no register; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_3 = 2'd3;

  typedef struct packed {
    logic [BUTTON_W-1:0] button;
    logic                released;
    logic                mod_a;
    logic                mod_b;
    logic                mod_l;
    logic                mod_r;
    logic                mod_select;
  } key_event_t;

  logic clk = 1'b0;
  logic rst;

  bac_cmd_if cmd_ch ();
  bac_evt_if evt_ch ();
  bac_cfg_if cfg_ch ();

  button_autorepeat_controller i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .evt (evt_ch),
    .cfg (cfg_ch)
  );

  always #1 clk = ~clk;

  // Predicted block state.
  logic [NUM_BUTTONS-1:0] held        = '0;
  bit                     rpt_on      = 1'b0;
  logic [BUTTON_W-1:0]    rpt_button  = '0;
  logic [TIME_W-1:0]      deadline    = '0;
  logic [CFG_W-1:0]       delay_ms    = INITIAL_DELAY_RESET;
  logic [CFG_W-1:0]       interval_ms = REPEAT_INTERVAL_RESET;

  // Pending requests and predicted events, each read in order from its own
  // index; the write and read counts never wrap within one run.
  item_t      req_mem[MAX_ITEMS];
  key_event_t evt_mem[MAX_ITEMS];
  int         req_count = 0;
  int         req_sent  = 0;
  int         evt_wr    = 0;
  int         evt_rd    = 0;

  // Generator shadow of the held mask and the running time.
  logic [NUM_BUTTONS-1:0] gen_held = '0;
  logic [TIME_W-1:0]      gen_now  = '0;

  int     idle_pct    = 15;
  int     send_gap    = 0;
  int     evt_stall   = 0;
  int     idle_cycles = 0;
  int     error_count = 0;
  bit     cmd_taken   = 1'b0;
  item_t  next_req;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic key_event_t snapshot(input logic [BUTTON_W-1:0] b, input logic rel);
    key_event_t ev;
    ev.button     = b;
    ev.released   = rel;
    ev.mod_a      = held[BTN_A];
    ev.mod_b      = held[BTN_B];
    ev.mod_l      = held[BTN_L];
    ev.mod_r      = held[BTN_R];
    ev.mod_select = held[BTN_SELECT];
    return ev;
  endfunction

  task automatic update_buttons(input item_t req, output bit fires, output key_event_t ev);
    logic [TIME_W-1:0] late;
    fires = 1'b0;
    ev    = '0;
    late  = req.time_ms - deadline;
    case (req.opcode)
      OP_PRESS: begin
        if (req.button < BTN_LIMIT && !held[req.button]) begin
          held[req.button] = 1'b1;
          fires = 1'b1;
          ev = snapshot(req.button, 1'b0);
          if (req.button < DPAD_LIMIT) begin
            rpt_on     = 1'b1;
            rpt_button = req.button;
            deadline   = req.time_ms + TIME_W'(delay_ms);
          end
        end
      end
      OP_RELEASE: begin
        if (req.button < BTN_LIMIT && held[req.button]) begin
          held[req.button] = 1'b0;
          fires = 1'b1;
          ev = snapshot(req.button, 1'b1);
          if (req.button == rpt_button || req.button == BTN_A || req.button == BTN_B)
            rpt_on = 1'b0;
        end
      end
      OP_TICK: begin
        // Due when the wrapped difference to the deadline is not negative.
        if (rpt_on && !late[TIME_W-1]) begin
          fires = 1'b1;
          ev = snapshot(rpt_button, 1'b0);
          deadline = req.time_ms + TIME_W'(interval_ms);
        end
      end
      default: begin
        held   = '0;
        rpt_on = 1'b0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [BUTTON_W-1:0] want,
                             input logic [BUTTON_W-1:0] got);
    if (got !== want)
      report_error($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  // Handshake sampling, prediction and event checking.
  always @(posedge clk) begin
    key_event_t want;
    key_event_t got;
    bit         fires;
    bit         evt_taken;
    bit         cfg_taken;
    cmd_taken = !rst && cmd_ch.valid && cmd_ch.ready;
    evt_taken = !rst && evt_ch.valid && evt_ch.ready;
    cfg_taken = !rst && cfg_ch.valid && cfg_ch.ready;
    if (cfg_taken) begin
      case (cfg_ch.reg_index)
        CFG_INITIAL_DELAY:   delay_ms = cfg_ch.data;
        CFG_REPEAT_INTERVAL: interval_ms = cfg_ch.data;
        default: ;
      endcase
    end
    if (cmd_taken) begin
      update_buttons('{opcode_t'(cmd_ch.opcode), cmd_ch.button, cmd_ch.time_ms}, fires, want);
      if (fires) begin
        if (evt_wr < MAX_ITEMS) begin
          evt_mem[evt_wr] = want;
          evt_wr++;
        end else begin
          report_error("too many predicted events");
        end
      end
    end
    if (evt_taken) begin
      got = '{evt_ch.event_button, evt_ch.released, evt_ch.mod_a, evt_ch.mod_b,
              evt_ch.mod_l, evt_ch.mod_r, evt_ch.mod_select};
      if (evt_rd == evt_wr) begin
        report_error($sformatf("event %p arrived with none expected", got));
      end else begin
        want = evt_mem[evt_rd];
        evt_rd++;
        check_field("event_button", want.button, got.button);
        check_field("released", BUTTON_W'(want.released), BUTTON_W'(got.released));
        check_field("mod_a", BUTTON_W'(want.mod_a), BUTTON_W'(got.mod_a));
        check_field("mod_b", BUTTON_W'(want.mod_b), BUTTON_W'(got.mod_b));
        check_field("mod_l", BUTTON_W'(want.mod_l), BUTTON_W'(got.mod_l));
        check_field("mod_r", BUTTON_W'(want.mod_r), BUTTON_W'(got.mod_r));
        check_field("mod_select", BUTTON_W'(want.mod_select), BUTTON_W'(got.mod_select));
      end
    end
    if (cmd_taken || evt_taken || cfg_taken)
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  // Request driver with random gaps between requests.
  always @(negedge clk) begin
    if (!rst && (!cmd_ch.valid || cmd_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
      end else if (req_sent != req_count) begin
        next_req = req_mem[req_sent];
        req_sent++;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= next_req.opcode;
        cmd_ch.button  <= next_req.button;
        cmd_ch.time_ms <= next_req.time_ms;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          send_gap = $urandom_range(1, 17);
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // Event receiver with random stall bursts.
  always @(negedge clk) begin
    if (evt_stall != 0) begin
      evt_stall--;
      evt_ch.ready <= 1'b0;
    end else begin
      evt_ch.ready <= 1'b1;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        evt_stall = $urandom_range(1, 17);
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT)
      @(negedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic queue_request(input opcode_t op, input logic [BUTTON_W-1:0] b,
                               input logic [TIME_W-1:0] t);
    item_t req;
    req.opcode  = op;
    req.button  = b;
    req.time_ms = t;
    if (req_count < MAX_ITEMS) begin
      req_mem[req_count] = req;
      req_count++;
    end else begin
      report_error("request store full");
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    @(posedge clk);
    while (!cfg_ch.ready)
      @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Returns at a rising edge once every request is sent and every event has come.
  task automatic wait_drained();
    do
      @(posedge clk);
    while (req_sent != req_count || cmd_ch.valid || evt_rd != evt_wr);
    // A request without an event can still be in the two-stage pipeline.
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_directed();
    queue_request(OP_PRESS, 4'd0, 32'd1000);
    queue_request(OP_PRESS, 4'd0, 32'd1010);
    queue_request(OP_TICK, 4'd0, 32'd1399);
    queue_request(OP_TICK, 4'd0, 32'd1400);
    queue_request(OP_PRESS, BTN_A, 32'd1450);
    queue_request(OP_TICK, 4'd0, 32'd1500);
    queue_request(OP_PRESS, BTN_B, 32'd1510);
    queue_request(OP_PRESS, BTN_L, 32'd1520);
    queue_request(OP_PRESS, BTN_R, 32'd1530);
    queue_request(OP_PRESS, BTN_SELECT, 32'd1540);
    queue_request(OP_PRESS, 4'd9, 32'd1550);
    queue_request(OP_RELEASE, BTN_A, 32'd0);
    queue_request(OP_TICK, 4'd0, 32'd5000);
    queue_request(OP_RELEASE, 4'd0, 32'hFFFF_FFFF);
    queue_request(OP_RELEASE, 4'd0, 32'd0);
    queue_request(OP_PRESS, 4'd10, 32'd6000);
    queue_request(OP_RELEASE, 4'd15, 32'd6000);
    // The first deadline wraps past zero.
    queue_request(OP_PRESS, 4'd3, 32'hFFFF_FF00);
    queue_request(OP_TICK, 4'd0, 32'hFFFF_FFFF);
    queue_request(OP_TICK, 4'd0, 32'h0000_0090);
    // A second D-pad press takes the repeat over from the first.
    queue_request(OP_PRESS, 4'd1, 32'h0000_0100);
    queue_request(OP_RELEASE, 4'd3, 32'h0000_0200);
    queue_request(OP_TICK, 4'd0, 32'h0000_0290);
    // Half the time range ahead counts as early; one less counts as due.
    queue_request(OP_TICK, 4'd0, 32'h8000_02F4);
    queue_request(OP_TICK, 4'd0, 32'h8000_02F3);
    queue_request(OP_RELEASE, BTN_B, 32'd0);
    queue_request(OP_FOCUS_LOST, 4'd15, 32'hA5A5_5A5A);
    queue_request(OP_TICK, 4'd0, 32'hFFFF_FFFF);
    queue_request(OP_RELEASE, 4'd1, 32'd0);
  endtask

  task automatic queue_random_requests(input int count, input int span);
    int                  pick;
    logic [BUTTON_W-1:0] b;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 3)
        gen_now += $urandom();
      else
        gen_now += $urandom_range(0, span);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_request(OP_TICK, BUTTON_W'($urandom_range(0, 15)), gen_now);
      end else if (pick < 66) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          b = BUTTON_W'($urandom_range(0, 3));
        else if (pick < 95)
          b = BUTTON_W'($urandom_range(4, 9));
        else
          b = BUTTON_W'($urandom_range(10, 15));
        if (b < BTN_LIMIT)
          gen_held[b] = 1'b1;
        queue_request(OP_PRESS, b, gen_now);
      end else if (pick < 96) begin
        b = BUTTON_W'($urandom_range(0, 15));
        // Most releases hit a button that is actually down.
        if (gen_held != '0 && $urandom_range(0, 3) != 0) begin
          b = BUTTON_W'($urandom_range(0, NUM_BUTTONS - 1));
          while (!gen_held[b])
            b = (b == NUM_BUTTONS - 1) ? '0 : b + 1'b1;
        end
        if (b < BTN_LIMIT)
          gen_held[b] = 1'b0;
        queue_request(OP_RELEASE, b, $urandom());
      end else begin
        gen_held = '0;
        queue_request(OP_FOCUS_LOST, BUTTON_W'($urandom_range(0, 15)), $urandom());
      end
    end
  endtask

  initial begin
    int d;
    int i;
    int span;
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.opcode    = '0;
    cmd_ch.button    = '0;
    cmd_ch.time_ms   = '0;
    evt_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_directed();
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin d = 0; i = 0; end
        1: begin d = 65535; i = 65535; end
        2: begin d = 1; i = 0; end
        3: begin d = 0; i = 65535; end
        4: begin d = 65535; i = 1; end
        5: begin d = $urandom_range(0, 65535); i = $urandom_range(0, 65535); end
        default: begin d = $urandom_range(0, 600); i = $urandom_range(0, 200); end
      endcase
      write_reg(CFG_INITIAL_DELAY, CFG_W'(d));
      write_reg(CFG_REPEAT_INTERVAL, CFG_W'(i));
      if (p == 2) begin
        write_reg(CFG_NO_REG_2, CFG_W'($urandom_range(0, 65535)));
        write_reg(CFG_NO_REG_3, CFG_W'($urandom_range(0, 65535)));
      end
      @(posedge clk);
      span = ((d > i) ? d : i) / 3 + 2;
      // Odd phases start close to the top of the time range so deadlines wrap.
      if (p % 2 == 1)
        gen_now = 32'hFFFF_FFFF - $urandom_range(0, 20 * span);
      idle_pct = (p == NUM_PHASES - 1) ? 0 : ((p % 2 == 1) ? 25 : 8);
      queue_random_requests(ITEMS_PER_PHASE, span);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
hdl/bac_pkg.sv
hdl/bac_if.sv
hdl/bac_cfg_regs.sv
hdl/bac_in_stage.sv
hdl/bac_core.sv
hdl/button_autorepeat_controller.sv
hdl/bac_checker.sv
verif/button_autorepeat_controller_test.sv
